@@ src/rpcbf_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcbf_pkg
// Shared constants for the row projection character band finder: default
// sizes, search rules, register indexes, reset values and fixed port widths.
// ----------------------------------------------------------------------------
package rpcbf_pkg;

	// Default storage sizes.
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 256;

	// Search rules.
	localparam int MIN_ROWS = 12;
	localparam int RUN_LEN  = 6;
	localparam int RUN_W    = $clog2(RUN_LEN + 1);

	// Pixel and result widths.
	localparam int PIX_W  = 8;
	localparam int EDGE_W = 7;
	localparam logic [PIX_W-1:0] WHITE_PIXEL = 8'hFF;

	// Configuration port.
	localparam int ROWS_CFG_W = 7;
	localparam int COLS_CFG_W = 9;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd36;
	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd136;

endpackage

@@ src/row_projection_char_band_finder_unit.sv @@
// ----------------------------------------------------------------------------
// row_projection_char_band_finder_unit
// Counts white pixels per row of a binarized image into a row-count memory,
// then scans that memory once to find the band that holds the characters.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while busy is low.
// After the last pixel of an image, busy stays high while the scan reads all R rows:
// one memory read per row, the registered read data, then a finalize state.
// The result beat appears on done in the same cycle that busy falls; it cannot be held.
// Reset clears the counters, the state machine and the registers to 36 rows
// and 136 columns; the row-count memory is not cleared and needs no sweep.
module row_projection_char_band_finder_unit #(
	parameter int MAX_ROWS = rpcbf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = rpcbf_pkg::MAX_COLS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [rpcbf_pkg::PIX_W-1:0]            pixel_value,
	input  logic                                   cfg_wr_en,
	input  logic [rpcbf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rpcbf_pkg::CFG_W-1:0]            cfg_data,
	output logic                                   done,
	output logic signed [rpcbf_pkg::EDGE_W-1:0]    upper_edge,
	output logic [rpcbf_pkg::EDGE_W-1:0]           lower_edge
);
	import rpcbf_pkg::*;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int RN_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int MW_W  = CW + 4;
	localparam int SUM_W = (RN_W > EDGE_W) ? RN_W : EDGE_W;

	localparam logic [1:0] ST_ACC  = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]            state_q;
	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;
	logic [RN_W-1:0]       rows_eff;
	logic [CW-1:0]         cols_eff;
	logic [RN_W-1:0]       half_rows;

	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [CW-1:0]         white_q;
	logic [CW-1:0]         white_next;
	logic                  accept;
	logic                  last_col;
	logic                  last_row;

	logic [CW-1:0]         mem [MAX_ROWS];
	logic                  mem_we;
	logic                  rd_en;
	logic [CW-1:0]         rd_data_s1;

	logic [RN_W-1:0]       iss_q;
	logic                  vld_s1;
	logic                  last_s1;
	logic [ROW_W-1:0]      k_s1;

	logic [RUN_W-1:0]      run_q;
	logic                  zero_seen_q;
	logic                  tfound_q;
	logic [ROW_W-1:0]      top_q;
	logic                  bfound_q;
	logic [ROW_W-1:0]      bot_q;
	logic                  lead_active_q;
	logic [RN_W-1:0]       lead_q;
	logic [ROW_W-1:0]      lastnw_q;

	logic                  row_nz;
	logic                  row_mw;
	logic [MW_W-1:0]       cnt_x10;
	logic [MW_W-1:0]       cols_x9;
	logic [ROW_W-1:0]      run_start;
	logic                  top_hit;
	logic                  bot_hit;

	logic [SUM_W-1:0]      top_sel;
	logic [SUM_W-1:0]      bot_sel;
	logic [SUM_W-1:0]      up_val;
	logic [SUM_W-1:0]      low_val;
	logic                  done_q;
	logic [EDGE_W-1:0]     upper_q;
	logic [EDGE_W-1:0]     lower_q;

	// Saturate the configured image size to the supported range.
	always_comb begin
		if (rows_q < ROWS_CFG_W'(MIN_ROWS)) begin
			rows_eff = RN_W'(MIN_ROWS);
		end else if (32'(rows_q) > MAX_ROWS) begin
			rows_eff = RN_W'(MAX_ROWS);
		end else begin
			rows_eff = RN_W'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = CW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = CW'(cols_q);
		end
	end

	assign half_rows = rows_eff >> 1;
	assign busy      = (state_q != ST_ACC);
	assign accept    = start && !busy;

	// Pixel accumulation: position counters and the running white count.
	assign white_next = white_q + CW'(pixel_value == WHITE_PIXEL);
	assign last_col   = (CW'(col_q) + CW'(1)) == cols_eff;
	assign last_row   = (RN_W'(row_q) + RN_W'(1)) == rows_eff;
	assign mem_we     = accept && last_col;

	// Read side of the scan: one row address per cycle.
	assign rd_en = (state_q == ST_SCAN) && (iss_q < rows_eff);

	// Row-count memory, one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_q] <= white_next;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[iss_q[ROW_W-1:0]];
		end
	end

	// Per-row tests on the row just read.
	assign row_nz    = (rd_data_s1 != '0);
	assign cnt_x10   = (MW_W'(rd_data_s1) << 3) + (MW_W'(rd_data_s1) << 1);
	assign cols_x9   = (MW_W'(cols_eff) << 3) + MW_W'(cols_eff);
	assign row_mw    = (cnt_x10 >= cols_x9);
	assign run_start = k_s1 - ROW_W'(RUN_LEN - 1);

	// The first upper-half run of six nonzero rows after a zero row opens the top edge.
	assign top_hit = vld_s1 && row_nz && (run_q == RUN_W'(RUN_LEN - 1)) && zero_seen_q
		&& !tfound_q && (RN_W'(run_start) < half_rows);
	// A zero row that ends a run of at least six marks a bottom candidate; the
	// last one seen is the lowest.
	assign bot_hit = vld_s1 && !row_nz && (run_q == RUN_W'(RUN_LEN))
		&& (RN_W'(k_s1) >= half_rows + RN_W'(2));

	// Control state, configuration registers and the pixel counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			rows_q  <= ROWS_RESET;
			cols_q  <= COLS_RESET;
			col_q   <= '0;
			row_q   <= '0;
			white_q <= '0;
			iss_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			done_q <= (state_q == ST_FIN);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IMAGE_ROWS: rows_q <= cfg_data[ROWS_CFG_W-1:0];
					REG_IMAGE_COLS: cols_q <= cfg_data[COLS_CFG_W-1:0];
					default: ;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				white_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q   <= '0;
					white_q <= '0;
					if (last_row) begin
						row_q   <= '0;
						iss_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q   <= col_q + COL_W'(1);
					white_q <= white_next;
				end
			end
			case (state_q)
				ST_ACC: ;
				ST_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + RN_W'(1);
					end
					if (vld_s1 && last_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// Scan pipeline tags and the search registers.
	always_ff @(posedge clk) begin
		k_s1    <= iss_q[ROW_W-1:0];
		last_s1 <= (iss_q + RN_W'(1)) == rows_eff;
		if (accept && last_col && last_row) begin
			run_q         <= '0;
			zero_seen_q   <= 1'b0;
			tfound_q      <= 1'b0;
			bfound_q      <= 1'b0;
			lead_active_q <= 1'b1;
			lead_q        <= '0;
			lastnw_q      <= '0;
		end else if (vld_s1) begin
			if (!row_nz) begin
				run_q       <= '0;
				zero_seen_q <= 1'b1;
			end else if (run_q != RUN_W'(RUN_LEN)) begin
				run_q <= run_q + RUN_W'(1);
			end
			if (top_hit) begin
				tfound_q <= 1'b1;
				top_q    <= run_start;
			end
			if (bot_hit) begin
				bfound_q <= 1'b1;
				bot_q    <= k_s1 - ROW_W'(1);
			end
			if (lead_active_q && row_mw) begin
				lead_q <= lead_q + RN_W'(1);
			end else begin
				lead_active_q <= 1'b0;
			end
			if ((k_s1 != '0) && !row_mw) begin
				lastnw_q <= k_s1;
			end
		end
	end

	// Final edges: the band search wins, the mostly-white skip is the fallback.
	assign top_sel = tfound_q ? SUM_W'(top_q) : SUM_W'(lead_q);
	assign bot_sel = bfound_q ? SUM_W'(bot_q) : SUM_W'(lastnw_q);
	assign up_val  = top_sel - SUM_W'(1);
	assign low_val = bot_sel + SUM_W'(1);

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			upper_q <= up_val[EDGE_W-1:0];
			lower_q <= low_val[EDGE_W-1:0];
		end
	end

	assign done       = done_q;
	assign upper_edge = $signed(upper_q);
	assign lower_edge = lower_q;

	// The result beat lasts exactly one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat held longer than one cycle");

	// Finalizing always produces a result beat in the next cycle.
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (done && !busy))
		else $error("finalize did not produce a result beat");

	// Read data is only consumed during the scan.
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN))
		else $error("row read outside the scan");

	// No row count is written while the scan reads the memory.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("row memory written during the scan");

	// A bottom candidate always lies in the lower half.
	a_bottom_half: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && bfound_q) |-> (RN_W'(bot_q) > half_rows))
		else $error("bottom edge found in the upper half");

endmodule
